>>> rtl/core/rlcp_pkg.sv
// Shared types and constants for the relay list command parser.
package rlcp_pkg;

   localparam int unsigned LINE_COUNT = 1024;
   localparam int unsigned BUS_COUNT  = 4;

   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // last digit position of a token (prefix sits at position 0)
   localparam logic [2:0] TOKEN_LAST_POS = 3'd6;

   localparam logic [2:0] KIND_SEQU = 3'd4;
   localparam logic [2:0] KIND_GRUP = 3'd5;
   localparam logic [2:0] KIND_NONE = 3'd6;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FMT  = 2'd1;
   localparam logic [1:0] ST_PARA = 2'd2;

   localparam logic [1:0] PFX_AT    = 2'd0;
   localparam logic [1:0] PFX_COMMA = 2'd1;
   localparam logic [1:0] PFX_COLON = 2'd2;
   localparam logic [1:0] PFX_BAD   = 2'd3;

   typedef struct packed {
      logic [2:0] op_kind;
      logic [1:0] bus_number;
      logic [9:0] line_number;
      logic       list_end;
      logic [1:0] status;
      logic       last_of_item;
   } res_type;

endpackage

>>> rtl/core/rlcp_parse.sv
// Character parser: token state, digit accumulation and result generation.
module rlcp_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_code,
   input  logic              is_last,
   input  logic [1:0]        op_type,
   output rlcp_pkg::res_type res0,
   output rlcp_pkg::res_type res1,
   output logic [1:0]        res_count
);
   import rlcp_pkg::*;

   logic        started_ff, started_in;
   logic [2:0]  pos_ff, pos_in;
   logic [1:0]  prefix_ff, prefix_in;
   logic [6:0]  bus_ff, bus_in;
   logic [13:0] line_ff, line_in;
   logic [1:0]  op_ff, op_in;
   logic [1:0]  ferr_ff, ferr_in;
   logic        derr_ff, derr_in;

   logic [3:0]  digit;
   logic        is_digit;
   logic [1:0]  end_status;

   function automatic res_type make_res(logic [2:0] kind, logic [6:0] bus, logic [13:0] line,
                                        logic lend, logic [1:0] st, logic lst);
      res_type r;
      r.op_kind      = kind;
      r.bus_number   = bus[1:0];
      r.line_number  = line[9:0];
      r.list_end     = lend;
      r.status       = st;
      r.last_of_item = lst;
      return r;
   endfunction

   always_comb begin
      started_in = started_ff;
      pos_in     = pos_ff;
      prefix_in  = prefix_ff;
      bus_in     = bus_ff;
      line_in    = line_ff;
      op_in      = op_ff;
      ferr_in    = ferr_ff;
      derr_in    = derr_ff;
      res0       = make_res(KIND_NONE, 7'd0, 14'd0, 1'b0, ST_OK, 1'b1);
      res1       = make_res(KIND_NONE, 7'd0, 14'd0, 1'b0, ST_OK, 1'b1);
      res_count  = 2'd0;
      digit      = 4'(char_code - CH_ZERO);
      is_digit   = char_code inside {[CH_ZERO:CH_NINE]};
      end_status = ST_OK;

      if (char_code != CH_CLOSE) begin
         end_status = ST_FMT;
      end else if (ferr_ff != ST_OK) begin
         end_status = ferr_ff;
      end else if (pos_ff != 3'd0) begin
         end_status = ST_FMT;
      end

      if (accept) begin
         if (!started_ff) begin
            op_in      = op_type;
            started_in = 1'b1;
            pos_in     = 3'd0;
            if (char_code != CH_OPEN) begin
               ferr_in = ST_FMT;
            end
            if (is_last) begin
               res0      = make_res(KIND_NONE, 7'd0, 14'd0, 1'b1, ST_FMT, 1'b1);
               res_count = 2'd1;
            end
         end else if (is_last) begin
            if (end_status == ST_OK) begin
               res0 = make_res(KIND_GRUP, 7'd0, 14'd1, 1'b1, ST_OK, 1'b1);
            end else begin
               res0 = make_res(KIND_NONE, 7'd0, 14'd0, 1'b1, end_status, 1'b1);
            end
            res_count = 2'd1;
         end else if (pos_ff == 3'd0) begin
            case (char_code)
               CH_AT:    prefix_in = PFX_AT;
               CH_COMMA: prefix_in = PFX_COMMA;
               CH_COLON: prefix_in = PFX_COLON;
               default:  prefix_in = PFX_BAD;
            endcase
            bus_in  = 7'd0;
            line_in = 14'd0;
            derr_in = 1'b0;
            pos_in  = 3'd1;
         end else begin
            if (is_digit) begin
               if (pos_ff <= 3'd2) begin
                  bus_in = 7'(bus_ff * 7'd10) + {3'd0, digit};
               end else begin
                  line_in = 14'(line_ff * 14'd10) + {10'd0, digit};
               end
            end else begin
               derr_in = 1'b1;
            end
            if (pos_ff >= TOKEN_LAST_POS) begin
               pos_in = 3'd0;
               if (ferr_ff == ST_OK) begin
                  if (derr_in) begin
                     ferr_in = ST_FMT;
                  end else if (32'(line_in) >= LINE_COUNT || 32'(bus_in) >= BUS_COUNT) begin
                     ferr_in = ST_PARA;
                  end else begin
                     case (prefix_ff)
                        PFX_AT: begin
                           res0 = make_res(KIND_GRUP, 7'd0, 14'd0, 1'b0, ST_OK, 1'b0);
                           res1 = make_res({1'b0, op_ff}, bus_in, line_in, 1'b0, ST_OK, 1'b1);
                           res_count = 2'd2;
                        end
                        PFX_COMMA: begin
                           res0 = make_res({1'b0, op_ff}, bus_in, line_in, 1'b0, ST_OK, 1'b1);
                           res_count = 2'd1;
                        end
                        PFX_COLON: begin
                           res0 = make_res(KIND_SEQU, bus_in, line_in, 1'b0, ST_OK, 1'b1);
                           res_count = 2'd1;
                        end
                        default: ferr_in = ST_FMT;
                     endcase
                  end
               end
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end

         if (is_last) begin
            started_in = 1'b0;
            pos_in     = 3'd0;
            prefix_in  = PFX_AT;
            bus_in     = 7'd0;
            line_in    = 14'd0;
            op_in      = 2'd0;
            ferr_in    = ST_OK;
            derr_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pos_ff     <= 3'd0;
         prefix_ff  <= PFX_AT;
         bus_ff     <= 7'd0;
         line_ff    <= 14'd0;
         op_ff      <= 2'd0;
         ferr_ff    <= ST_OK;
         derr_ff    <= 1'b0;
      end else begin
         started_ff <= started_in;
         pos_ff     <= pos_in;
         prefix_ff  <= prefix_in;
         bus_ff     <= bus_in;
         line_ff    <= line_in;
         op_ff      <= op_in;
         ferr_ff    <= ferr_in;
         derr_ff    <= derr_in;
      end
   end

endmodule

>>> rtl/core/relay_list_command_parser.sv
// Top level of the relay list command parser: parser plus result queue.
//
//   channel   dir  tdata                     tuser      tlast
//   req_      in   char_code                 op_type    is_last
//   rsp_      out  bus,line,status,last_item op_kind    list_end
//
// One character is taken per cycle while req_tready is high; the results it causes
// land in a four-entry result queue at the same edge and leave one per cycle.
// A group-start token yields two results, so req_tready needs two free slots.
// Reset is synchronous and clears parser state and the queue.
// A stall on rsp_ only holds req_ once the queue has fewer than two free slots.
module relay_list_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [1:0]  req_tuser,   // [1:0] op_type
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] bus_number, [11:2] line_number,
                                    // [13:12] status, [14] last_of_item, [15] zero
   output logic [2:0]  rsp_tuser,   // [2:0] op_kind
   output logic        rsp_tlast
);
   import rlcp_pkg::*;

   logic       req_xfer;
   logic       rsp_xfer;
   res_type    res0;
   res_type    res1;
   logic [1:0] res_count;
   res_type    queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   res_type    head;

   assign req_tready = (count_ff <= 3'd2);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   rlcp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_xfer),
      .char_code (req_tdata),
      .is_last   (req_tlast),
      .op_type   (req_tuser),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff + res_count;
      rd_ptr_in = rd_ptr_ff + {1'b0, rsp_xfer};
      count_in  = count_ff + {1'b0, res_count} - {2'd0, rsp_xfer};
   end

   always_ff @(posedge clock) begin
      if (res_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (res_count == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = queue_ff[rd_ptr_ff];
   assign rsp_tdata = {1'b0, head.last_of_item, head.status, head.line_number, head.bus_number};
   assign rsp_tuser = head.op_kind;
   assign rsp_tlast = head.list_end;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_results_need_accept: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |-> res_count == 2'd0)
      else $error("results without an accepted character");

   a_end_closes_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> head.last_of_item)
      else $error("list end result not last of its character");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> head.status == ST_OK)
      else $error("status reported before list end");

endmodule
